@@ design/matrix3_inverse_macros.svh @@
// Assertion helpers shared by the matrix inverse design.
`ifndef MATRIX3_INVERSE_MACROS_SVH
`define MATRIX3_INVERSE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define M3INV_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define M3INV_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also covers the reset cycles.
`define M3INV_ASSERT_RST(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/m3inv_pkg.sv @@
`timescale 1ns / 1ps

package m3inv_pkg;

    // Element width and matrix size.
    localparam int ELEM_W = 32;
    localparam int N_ELEM = 9;
    localparam int DATA_W = ELEM_W * N_ELEM;

    // Width of a 2x2 minor and of the exact determinant.
    localparam int COF_W = 64;
    localparam int DET_W = 98;

    // Quotient bits: 32 value bits plus one overflow bit.
    localparam int QUO_W = 33;

    // Flag positions in the output tuser.
    localparam int USER_SING = 0;
    localparam int USER_SAT  = 1;
    localparam int USER_W    = 2;

    typedef logic signed [ELEM_W-1:0] t_elem;
    typedef logic signed [COF_W-1:0]  t_cof;
    typedef logic signed [DET_W-1:0]  t_det;

endpackage

@@ design/matrix3_inverse.sv @@
`timescale 1ns / 1ps
// Throughput: one matrix per cycle when the output is not stalled.
// The 33 restoring-division stages are fully pipelined.
// A stall on the output holds the whole pipeline through one shared enable.
// Reset (synchronous, active low) clears all valid bits; data registers are not reset.
`include "matrix3_inverse_macros.svh"

module matrix3_inverse #(
    parameter int FRAC_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // in_r0c0, in_r0c1, in_r0c2, in_r1c0, ..., in_r2c2, 32 bits each from bit 0 up
    input  logic [m3inv_pkg::DATA_W-1:0]  s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // out_r0c0, out_r0c1, out_r0c2, out_r1c0, ..., out_r2c2, 32 bits each from bit 0 up
    output logic [m3inv_pkg::DATA_W-1:0]  m_axis_tdata,
    // bit 0 singular, bit 1 saturated
    output logic [m3inv_pkg::USER_W-1:0]  m_axis_tuser
);

    localparam int EW = m3inv_pkg::ELEM_W;
    localparam int NE = m3inv_pkg::N_ELEM;
    localparam int CW = m3inv_pkg::COF_W;
    localparam int DW = m3inv_pkg::DET_W;
    localparam int QW = m3inv_pkg::QUO_W;
    localparam int DAW = m3inv_pkg::DATA_W;
    localparam int NUM_W = CW + 2 * FRAC_BITS;
    localparam int RW = (NUM_W > DW) ? NUM_W : DW;

    logic en;

    // The whole pipeline moves while the output register is free or being taken.
    assign en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    // Stage 1: input register.
    logic             r_v1;
    m3inv_pkg::t_elem r_a1 [NE];
    logic [DAW-1:0]   r_d1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en) begin
            r_v1 <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d1 <= s_axis_tdata;
            for (int e = 0; e < NE; e++) begin
                r_a1[e] <= s_axis_tdata[e*EW +: EW];
            end
        end
    end

    // Stage 2: the two products of every 2x2 minor.
    logic             r_v2;
    m3inv_pkg::t_cof  r_pa2 [NE];
    m3inv_pkg::t_cof  r_pb2 [NE];
    m3inv_pkg::t_elem r_a2 [3];
    logic [DAW-1:0]   r_d2;

    for (genvar gi = 0; gi < 3; gi++) begin : g_minor_row
        for (genvar gj = 0; gj < 3; gj++) begin : g_minor_col
            localparam int R1 = (gi + 1) % 3;
            localparam int R2 = (gi + 2) % 3;
            localparam int C1 = (gj + 1) % 3;
            localparam int C2 = (gj + 2) % 3;
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_pa2[gi*3+gj] <= r_a1[R1*3+C1] * r_a1[R2*3+C2];
                    r_pb2[gi*3+gj] <= r_a1[R1*3+C2] * r_a1[R2*3+C1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d2 <= r_d1;
            for (int j = 0; j < 3; j++) begin
                r_a2[j] <= r_a1[j];
            end
        end
    end

    // Stage 3: cofactors.
    logic             r_v3;
    m3inv_pkg::t_cof  r_cof3 [NE];
    m3inv_pkg::t_elem r_a3 [3];
    logic [DAW-1:0]   r_d3;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d3 <= r_d2;
            for (int e = 0; e < NE; e++) begin
                r_cof3[e] <= r_pa2[e] - r_pb2[e];
            end
            for (int j = 0; j < 3; j++) begin
                r_a3[j] <= r_a2[j];
            end
        end
    end

    // Stage 4: first-row element times cofactor, split into two 32-bit halves.
    logic                r_v4;
    logic signed [64:0]  r_pl4 [3];
    logic signed [63:0]  r_ph4 [3];
    m3inv_pkg::t_cof     r_cof4 [NE];
    logic [DAW-1:0]      r_d4;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d4 <= r_d3;
            for (int e = 0; e < NE; e++) begin
                r_cof4[e] <= r_cof3[e];
            end
            for (int j = 0; j < 3; j++) begin
                r_pl4[j] <= r_a3[j] * $signed({1'b0, r_cof3[j][31:0]});
                r_ph4[j] <= r_a3[j] * $signed(r_cof3[j][63:32]);
            end
        end
    end

    // Stage 5: recombine the halves into three determinant terms.
    logic             r_v5;
    m3inv_pkg::t_det  r_t5 [3];
    m3inv_pkg::t_cof  r_cof5 [NE];
    logic [DAW-1:0]   r_d5;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d5 <= r_d4;
            for (int e = 0; e < NE; e++) begin
                r_cof5[e] <= r_cof4[e];
            end
            for (int j = 0; j < 3; j++) begin
                r_t5[j] <= (DW'(r_ph4[j]) <<< 32) + DW'(r_pl4[j]);
            end
        end
    end

    // Stage 6: determinant.
    logic             r_v6;
    m3inv_pkg::t_det  r_det6;
    m3inv_pkg::t_cof  r_cof6 [NE];
    logic [DAW-1:0]   r_d6;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d6   <= r_d5;
            r_det6 <= r_t5[0] + r_t5[1] + r_t5[2];
            for (int e = 0; e < NE; e++) begin
                r_cof6[e] <= r_cof5[e];
            end
        end
    end

    // Valid bits of the front stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else if (en) begin
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
        end
    end

    // Divider pipeline: index 0 is the setup stage, index k resolves quotient bit QW-k.
    logic            r_dv   [QW+1];
    logic            r_sing [QW+1];
    logic [DW-1:0]   r_dmag [QW+1];
    logic [NE-1:0]   r_rneg [QW+1];
    logic [DAW-1:0]  r_dd   [QW+1];
    logic [RW-1:0]   r_rem  [QW+1][NE];
    logic [QW-1:0]   r_q    [QW+1][NE];

    logic            n_dneg;
    logic [DW-1:0]   n_dmag;

    // Determinant sign and magnitude.
    assign n_dneg = r_det6[DW-1];
    assign n_dmag = n_dneg ? DW'(-r_det6) : DW'(r_det6);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sing[0] <= (r_det6 == '0);
            r_dmag[0] <= n_dmag;
            r_dd[0]   <= r_d6;
        end
    end

    // Setup: numerator magnitude and result sign for each entry (transposed cofactor).
    for (genvar ge = 0; ge < NE; ge++) begin : g_setup
        localparam int CI = (ge % 3) * 3 + (ge / 3);
        logic [CW-1:0] n_mag;
        assign n_mag = r_cof6[CI][CW-1] ? CW'(-r_cof6[CI]) : CW'(r_cof6[CI]);
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_rem[0][ge]  <= RW'(n_mag) << (2 * FRAC_BITS);
                r_q[0][ge]    <= '0;
                r_rneg[0][ge] <= r_cof6[CI][CW-1] ^ n_dneg;
            end
        end
    end

    // Restoring division steps, one quotient bit per stage.
    for (genvar gk = 1; gk <= QW; gk++) begin : g_div
        localparam int B = QW - gk;
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sing[gk] <= r_sing[gk-1];
                r_dmag[gk] <= r_dmag[gk-1];
                r_rneg[gk] <= r_rneg[gk-1];
                r_dd[gk]   <= r_dd[gk-1];
            end
        end
        for (genvar ge = 0; ge < NE; ge++) begin : g_lane
            logic n_ge;
            assign n_ge = (r_rem[gk-1][ge] >> B) >= RW'(r_dmag[gk-1]);
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_rem[gk][ge] <= n_ge ? r_rem[gk-1][ge] - (RW'(r_dmag[gk-1]) << B)
                                          : r_rem[gk-1][ge];
                    r_q[gk][ge]   <= r_q[gk-1][ge] | (QW'(n_ge) << B);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= QW; k++) begin
                r_dv[k] <= 1'b0;
            end
        end else if (en) begin
            r_dv[0] <= r_v6;
            for (int k = 1; k <= QW; k++) begin
                r_dv[k] <= r_dv[k-1];
            end
        end
    end

    // Output stage: saturation, sign, and the singular bypass.
    logic [NE-1:0]  n_over;
    logic [DAW-1:0] n_data;

    for (genvar ge = 0; ge < NE; ge++) begin : g_out
        logic [EW-1:0] n_lim;
        logic [EW-1:0] n_val;
        assign n_lim = r_rneg[QW][ge] ? {1'b1, {(EW-1){1'b0}}} : {1'b0, {(EW-1){1'b1}}};
        assign n_over[ge] = r_q[QW][ge][QW-1] || (r_q[QW][ge][EW-1:0] > n_lim);
        assign n_val = n_over[ge] ? n_lim : r_q[QW][ge][EW-1:0];
        assign n_data[ge*EW +: EW] = r_sing[QW] ? r_dd[QW][ge*EW +: EW]
                                   : (r_rneg[QW][ge] ? -n_val : n_val);
    end

    logic r_out_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= r_dv[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            m_axis_tdata                      <= n_data;
            m_axis_tuser[m3inv_pkg::USER_SING] <= r_sing[QW];
            m_axis_tuser[m3inv_pkg::USER_SAT]  <= !r_sing[QW] && (|n_over);
        end
    end

    assign m_axis_tvalid = r_out_v;

    // Checks.
    `M3INV_ASSERT_NOW(a_sing_no_sat, m_axis_tvalid && m_axis_tuser[m3inv_pkg::USER_SING], !m_axis_tuser[m3inv_pkg::USER_SAT], "singular result flagged as saturated")
    `M3INV_ASSERT_NOW(a_nonzero_div, r_dv[0] && !r_sing[0], r_dmag[0] != '0, "nonsingular matrix with zero divisor")
    `M3INV_ASSERT_NEXT(a_sing_reach, en && r_dv[QW], m_axis_tvalid && (m_axis_tuser[m3inv_pkg::USER_SING] == $past(r_sing[QW])), "singular flag lost at output")
    `M3INV_ASSERT_RST(a_rst_clear, !i_rst_n, !m_axis_tvalid, "output valid after reset")

endmodule
